@@ src/collider_pair_contact_tracker_macros.svh @@
// assertion macros shared by the tracker modules
`ifndef COLLIDER_PAIR_CONTACT_TRACKER_MACROS_SVH
`define COLLIDER_PAIR_CONTACT_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define CPCT_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("cpct assertion failed");
`define CPCT_NEVER(name, clk, rst_n, expr) `CPCT_ASSERT(name, clk, rst_n, !(expr))
`else
`define CPCT_ASSERT(name, clk, rst_n, prop)
`define CPCT_NEVER(name, clk, rst_n, expr)
`endif
`endif

@@ src/cpct_pkg.sv @@
// ----------------------------------------------------------------------------
// cpct_pkg
// shared constants and types of the collider pair contact tracker
// ----------------------------------------------------------------------------
package cpct_pkg;
	localparam int ID_BITS     = 5;
	localparam int IDX_BITS    = 2 * ID_BITS;
	localparam int PAIRS       = 1 << IDX_BITS;
	localparam int POS_BITS    = 24;
	localparam int SIZE_BITS   = 16;
	localparam int SCALED_BITS = 23;
	localparam int SIZE_SCALE  = 100;
	localparam int QDEPTH      = 8;
	localparam int QPTR_BITS   = $clog2(QDEPTH);
	localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_ENTER = 2'd1,
		EV_STAY  = 2'd2,
		EV_EXIT  = 2'd3
	} contact_ev_t;

	typedef struct packed {
		logic [ID_BITS-1:0] lid;
		logic [ID_BITS-1:0] rid;
		logic               hit;
		contact_ev_t        contact_ev;
	} pair_item_t;
endpackage

@@ src/cpct_geom.sv @@
// ----------------------------------------------------------------------------
// cpct_geom
// six stage overlap pipeline: box-box, circle-circle and circle-box tests
// ----------------------------------------------------------------------------
module cpct_geom (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic [cpct_pkg::ID_BITS-1:0]           left_id,
	input  logic [cpct_pkg::ID_BITS-1:0]           right_id,
	input  logic                                   left_is_circle,
	input  logic                                   right_is_circle,
	input  logic signed [cpct_pkg::POS_BITS-1:0]   left_x,
	input  logic signed [cpct_pkg::POS_BITS-1:0]   left_y,
	input  logic signed [cpct_pkg::POS_BITS-1:0]   right_x,
	input  logic signed [cpct_pkg::POS_BITS-1:0]   right_y,
	input  logic [cpct_pkg::SIZE_BITS-1:0]         left_w,
	input  logic [cpct_pkg::SIZE_BITS-1:0]         left_h,
	input  logic [cpct_pkg::SIZE_BITS-1:0]         right_w,
	input  logic [cpct_pkg::SIZE_BITS-1:0]         right_h,
	output logic                                   out_valid,
	output cpct_pkg::pair_item_t                   out_item
);
	import cpct_pkg::*;

	localparam int CW = 26;
	localparam int RW = 24;

	function automatic logic signed [CW-1:0] dbl_corner(input logic signed [POS_BITS-1:0] x);
		dbl_corner = {x[POS_BITS-1], x, 1'b0};
	endfunction

	function automatic logic signed [CW-1:0] dbl_center(input logic signed [POS_BITS-1:0] x,
			input logic [SCALED_BITS-1:0] w);
		dbl_center = dbl_corner(x) + $signed({3'b000, w});
	endfunction

	function automatic logic signed [CW-1:0] dbl_far(input logic signed [POS_BITS-1:0] x,
			input logic [SCALED_BITS-1:0] w);
		dbl_far = dbl_corner(x) + $signed({2'b00, w, 1'b0});
	endfunction

	function automatic logic [CW-1:0] absd(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		absd = d[CW] ? CW'(-d) : d[CW-1:0];
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1
	logic [ID_BITS-1:0] lid_s1, rid_s1;
	logic lc_s1, rc_s1;
	logic signed [POS_BITS-1:0] lx_s1, ly_s1, rx_s1, ry_s1;
	logic [SCALED_BITS-1:0] lw_s1, lh_s1, rw_s1, rh_s1;
	// stage 2
	logic [ID_BITS-1:0] lid_s2, rid_s2;
	logic box_s2, mixed_s2;
	logic signed [CW-1:0] ax_s2, ay_s2, bx_s2, by_s2, lox_s2, loy_s2, hix_s2, hiy_s2;
	logic [RW-1:0] r_s2, sh_s2;
	// stage 3
	logic [ID_BITS-1:0] lid_s3, rid_s3;
	logic box_s3;
	logic signed [CW-1:0] ax_s3, ay_s3, px_s3, py_s3;
	logic [RW-1:0] r_s3, sh_s3;
	// stage 4
	logic [ID_BITS-1:0] lid_s4, rid_s4;
	logic box_s4;
	logic [CW-1:0] dx_s4, dy_s4;
	logic [RW-1:0] r_s4, sh_s4;
	// stage 5
	logic [ID_BITS-1:0] lid_s5, rid_s5;
	logic box_s5, boxhit_s5;
	logic [2*CW-1:0] dx2_s5, dy2_s5;
	logic [2*RW-1:0] r2_s5;
	// stage 6
	logic [ID_BITS-1:0] lid_s6, rid_s6;
	logic hit_s6;

	logic signed [CW-1:0] lcx, lcy, rcx, rcy, ccx, ccy;
	logic signed [POS_BITS-1:0] bxp, byp;
	logic [SCALED_BITS-1:0] cw, bw, bh;
	logic signed [CW-1:0] mx, my, clx, cly;

	always_comb begin
		lcx = dbl_center(lx_s1, lw_s1);
		lcy = dbl_center(ly_s1, lh_s1);
		rcx = dbl_center(rx_s1, rw_s1);
		rcy = dbl_center(ry_s1, rh_s1);
		ccx = lc_s1 ? lcx : rcx;
		ccy = lc_s1 ? lcy : rcy;
		cw  = lc_s1 ? lw_s1 : rw_s1;
		bxp = lc_s1 ? rx_s1 : lx_s1;
		byp = lc_s1 ? ry_s1 : ly_s1;
		bw  = lc_s1 ? rw_s1 : lw_s1;
		bh  = lc_s1 ? rh_s1 : lh_s1;
		// clamp circle center into the box
		mx  = (ax_s2 < hix_s2) ? ax_s2 : hix_s2;
		my  = (ay_s2 < hiy_s2) ? ay_s2 : hiy_s2;
		clx = (mx > lox_s2) ? mx : lox_s2;
		cly = (my > loy_s2) ? my : loy_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		lid_s1 <= left_id;
		rid_s1 <= right_id;
		lc_s1  <= left_is_circle;
		rc_s1  <= right_is_circle;
		lx_s1  <= left_x;
		ly_s1  <= left_y;
		rx_s1  <= right_x;
		ry_s1  <= right_y;
		lw_s1  <= SCALED_BITS'(SCALED_BITS'(left_w) * SCALED_BITS'(SIZE_SCALE));
		lh_s1  <= SCALED_BITS'(SCALED_BITS'(left_h) * SCALED_BITS'(SIZE_SCALE));
		rw_s1  <= SCALED_BITS'(SCALED_BITS'(right_w) * SCALED_BITS'(SIZE_SCALE));
		rh_s1  <= SCALED_BITS'(SCALED_BITS'(right_h) * SCALED_BITS'(SIZE_SCALE));

		lid_s2   <= lid_s1;
		rid_s2   <= rid_s1;
		box_s2   <= !lc_s1 && !rc_s1;
		mixed_s2 <= lc_s1 ^ rc_s1;
		ax_s2    <= (lc_s1 ^ rc_s1) ? ccx : lcx;
		ay_s2    <= (lc_s1 ^ rc_s1) ? ccy : lcy;
		bx_s2    <= rcx;
		by_s2    <= rcy;
		lox_s2   <= dbl_corner(bxp);
		loy_s2   <= dbl_corner(byp);
		hix_s2   <= dbl_far(bxp, bw);
		hiy_s2   <= dbl_far(byp, bh);
		r_s2     <= (lc_s1 ^ rc_s1) ? RW'(cw) : RW'(lw_s1) + RW'(rw_s1);
		sh_s2    <= RW'(lh_s1) + RW'(rh_s1);

		lid_s3 <= lid_s2;
		rid_s3 <= rid_s2;
		box_s3 <= box_s2;
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
		px_s3  <= mixed_s2 ? clx : bx_s2;
		py_s3  <= mixed_s2 ? cly : by_s2;
		r_s3   <= r_s2;
		sh_s3  <= sh_s2;

		lid_s4 <= lid_s3;
		rid_s4 <= rid_s3;
		box_s4 <= box_s3;
		dx_s4  <= absd(ax_s3, px_s3);
		dy_s4  <= absd(ay_s3, py_s3);
		r_s4   <= r_s3;
		sh_s4  <= sh_s3;

		lid_s5    <= lid_s4;
		rid_s5    <= rid_s4;
		box_s5    <= box_s4;
		boxhit_s5 <= (dx_s4 < CW'(r_s4)) && (dy_s4 < CW'(sh_s4));
		dx2_s5    <= dx_s4 * dx_s4;
		dy2_s5    <= dy_s4 * dy_s4;
		r2_s5     <= r_s4 * r_s4;

		lid_s6 <= lid_s5;
		rid_s6 <= rid_s5;
		hit_s6 <= box_s5 ? boxhit_s5
			: ((2*CW+1)'(dx2_s5) + (2*CW+1)'(dy2_s5) <= (2*CW+1)'(r2_s5));
	end

	assign out_valid           = v_s6;
	assign out_item.lid        = lid_s6;
	assign out_item.rid        = rid_s6;
	assign out_item.hit        = hit_s6;
	assign out_item.contact_ev = EV_NONE;
endmodule

@@ src/cpct_fifo.sv @@
// ----------------------------------------------------------------------------
// cpct_fifo
// small register queue of pair items with occupancy count
// ----------------------------------------------------------------------------
`include "collider_pair_contact_tracker_macros.svh"
module cpct_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  cpct_pkg::pair_item_t            wdata,
	input  logic                            pop,
	output cpct_pkg::pair_item_t            rdata,
	output logic                            empty,
	output logic [cpct_pkg::QCNT_BITS-1:0]  count
);
	import cpct_pkg::*;

	pair_item_t           mem [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_BITS'(push) - QCNT_BITS'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	assign rdata = mem[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

	`CPCT_NEVER(a_no_overflow, clk, arst_n, push && !do_pop && cnt_q == QCNT_BITS'(QDEPTH))
endmodule

@@ src/cpct_table.sv @@
// ----------------------------------------------------------------------------
// cpct_table
// pair state table: read, event decode and write back, cleared after reset
// ----------------------------------------------------------------------------
`include "collider_pair_contact_tracker_macros.svh"
module cpct_table (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  cpct_pkg::pair_item_t  in_item,
	output logic                  busy,
	output logic                  res_valid,
	output cpct_pkg::pair_item_t  res_item
);
	import cpct_pkg::*;

	logic                mem [PAIRS];
	logic                clr_q;
	logic [IDX_BITS-1:0] clr_idx_q;
	logic                v_q, rd_q, fwd_q, fwd_val_q;
	pair_item_t          b_q;
	logic [IDX_BITS-1:0] b_idx, go_idx;
	logic                wr_en, was;

	assign b_idx  = {b_q.lid, b_q.rid};
	assign go_idx = {in_item.lid, in_item.rid};
	assign wr_en  = v_q && (b_q.lid != b_q.rid);
	// the entry written this cycle is newer than what the memory read returns
	assign was    = fwd_q ? fwd_val_q : rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			v_q       <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == {IDX_BITS{1'b1}}) begin
					clr_q <= 1'b0;
				end
			end
			v_q <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= 1'b0;
		end else if (wr_en) begin
			mem[b_idx] <= b_q.hit;
		end
		if (go) begin
			rd_q      <= mem[go_idx];
			b_q       <= in_item;
			fwd_q     <= wr_en && (b_idx == go_idx);
			fwd_val_q <= b_q.hit;
		end
	end

	always_comb begin
		res_item = b_q;
		if (b_q.lid == b_q.rid) begin
			res_item.contact_ev = EV_NONE;
		end else if (b_q.hit) begin
			res_item.contact_ev = was ? EV_STAY : EV_ENTER;
		end else begin
			res_item.contact_ev = was ? EV_EXIT : EV_NONE;
		end
	end

	assign busy      = clr_q;
	assign res_valid = v_q;

	`CPCT_NEVER(a_no_go_in_clear, clk, arst_n, clr_q && go)
	`CPCT_ASSERT(a_one_cycle, clk, arst_n, go |=> res_valid)
	`CPCT_ASSERT(a_self_none, clk, arst_n, (res_valid && res_item.lid == res_item.rid) |-> (res_item.contact_ev == EV_NONE))
endmodule

@@ src/collider_pair_contact_tracker.sv @@
// ----------------------------------------------------------------------------
// collider_pair_contact_tracker
// pair overlap test with per-pair enter / stay / exit contact tracking
// ----------------------------------------------------------------------------
// After reset the block clears all 1024 entries of its pair table, with full
// held high. Each item then passes a six stage geometry pipeline, a queue of
// eight, a table read-modify-write and an output queue of eight. The front
// admits items as long as its queue has credit, one per cycle, and the table
// takes one item per cycle while the output queue has room, so back-to-back
// items stream at one per cycle when the output side is drained.
`include "collider_pair_contact_tracker_macros.svh"
module collider_pair_contact_tracker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [cpct_pkg::ID_BITS-1:0]         left_id,
	input  logic [cpct_pkg::ID_BITS-1:0]         right_id,
	input  logic                                 left_is_circle,
	input  logic                                 right_is_circle,
	input  logic signed [cpct_pkg::POS_BITS-1:0] left_x,
	input  logic signed [cpct_pkg::POS_BITS-1:0] left_y,
	input  logic signed [cpct_pkg::POS_BITS-1:0] right_x,
	input  logic signed [cpct_pkg::POS_BITS-1:0] right_y,
	input  logic [cpct_pkg::SIZE_BITS-1:0]       left_w,
	input  logic [cpct_pkg::SIZE_BITS-1:0]       left_h,
	input  logic [cpct_pkg::SIZE_BITS-1:0]       right_w,
	input  logic [cpct_pkg::SIZE_BITS-1:0]       right_h,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 touching,
	output logic [1:0]                           contact_event
);
	import cpct_pkg::*;

	logic                 accept, busy;
	logic                 g_valid, mid_empty, mid_pop, res_valid;
	pair_item_t           g_item, mid_item, res_item, out_item;
	logic [QCNT_BITS-1:0] cred_q, mid_count, out_count;

	assign accept = push && !full;
	assign full   = busy || (cred_q == QCNT_BITS'(QDEPTH));
	// keep room in the output queue for the item still in the table stage
	assign mid_pop = !mid_empty && !busy
		&& ((QCNT_BITS+1)'(out_count) + (QCNT_BITS+1)'(res_valid) < (QCNT_BITS+1)'(QDEPTH));

	// credits cover items in the geometry pipeline and in the middle queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			cred_q <= cred_q + QCNT_BITS'(accept) - QCNT_BITS'(mid_pop);
		end
	end

	cpct_geom u_geom (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (accept),
		.left_id         (left_id),
		.right_id        (right_id),
		.left_is_circle  (left_is_circle),
		.right_is_circle (right_is_circle),
		.left_x          (left_x),
		.left_y          (left_y),
		.right_x         (right_x),
		.right_y         (right_y),
		.left_w          (left_w),
		.left_h          (left_h),
		.right_w         (right_w),
		.right_h         (right_h),
		.out_valid       (g_valid),
		.out_item        (g_item)
	);

	cpct_fifo u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (g_valid),
		.wdata  (g_item),
		.pop    (mid_pop),
		.rdata  (mid_item),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	cpct_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (mid_pop),
		.in_item   (mid_item),
		.busy      (busy),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	cpct_fifo u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_valid),
		.wdata  (res_item),
		.pop    (pop),
		.rdata  (out_item),
		.empty  (empty),
		.count  (out_count)
	);

	assign touching      = out_item.hit;
	assign contact_event = out_item.contact_ev;

	`CPCT_ASSERT(a_credit_bound, clk, arst_n, cred_q <= QCNT_BITS'(QDEPTH))
	`CPCT_ASSERT(a_mid_covered, clk, arst_n, mid_count <= cred_q)
endmodule
